// ----- rtl/pic_pkg.sv -----
package pic_pkg;

	localparam int POSITIONS_DEF    = 128;
	localparam int MAX_PATTERNS_DEF = 256;

	// Field widths of the item and register ports
	localparam int CMD_W   = 2;
	localparam int PIDX_W  = 7;
	localparam int PAT_W   = 8;
	localparam int SLEN_W  = 8;
	localparam int PCNT_W  = 9;
	localparam int CFGI_W  = 1;
	localparam int CFGD_W  = 9;
	// Walk counter: holds any position or pattern count up to 256
	localparam int CNT_W   = 9;

	localparam logic [CMD_W-1:0] CMD_WRITE_POS = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COMPUTE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ_POS  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ_MAP  = 2'd3;

	localparam logic [CFGI_W-1:0] CFG_SONG_LENGTH   = 1'b0;
	localparam logic [CFGI_W-1:0] CFG_PATTERN_COUNT = 1'b1;

	typedef struct packed {
		logic load;
		logic clr;
		logic mark_rd;
		logic cnt_clr;
		logic rank_step;
		logic rank_fin;
		logic rm_rd;
		logic rm_rank;
		logic rm_wr;
		logic out_load;
	} pic_cmd_t;

	typedef struct packed {
		logic pos_done;
		logic pat_done;
		logic out_free;
	} pic_status_t;

endpackage

// ----- rtl/pic_ctrl.sv -----
module pic_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pic_pkg::CMD_W-1:0]     command,
	input  pic_pkg::pic_status_t          st,
	output pic_pkg::pic_cmd_t             cmd
);
	import pic_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_RESP    = 4'd1;
	localparam logic [3:0] S_CLR     = 4'd2;
	localparam logic [3:0] S_MARK    = 4'd3;
	localparam logic [3:0] S_RANK    = 4'd4;
	localparam logic [3:0] S_RM_RD   = 4'd5;
	localparam logic [3:0] S_RM_RANK = 4'd6;
	localparam logic [3:0] S_RM_WR   = 4'd7;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (command == CMD_COMPUTE) ? S_CLR : S_RESP;
				end
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_CLR: begin
				cmd.clr = 1'b1;
				state_d = S_MARK;
			end
			S_MARK: begin
				// the last pending mark lands on the same edge as the switch
				if (!st.pos_done) begin
					cmd.mark_rd = 1'b1;
				end else begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_RANK;
				end
			end
			S_RANK: begin
				if (!st.pat_done) begin
					cmd.rank_step = 1'b1;
				end else begin
					cmd.rank_fin = 1'b1;
					state_d      = S_RM_RD;
				end
			end
			S_RM_RD: begin
				if (!st.pos_done) begin
					cmd.rm_rd = 1'b1;
					state_d   = S_RM_RANK;
				end else begin
					state_d = S_RESP;
				end
			end
			S_RM_RANK: begin
				cmd.rm_rank = 1'b1;
				state_d     = S_RM_WR;
			end
			S_RM_WR: begin
				cmd.rm_wr = 1'b1;
				state_d   = S_RM_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/pic_dpath.sv -----
module pic_dpath #(
	parameter int POSITIONS    = pic_pkg::POSITIONS_DEF,
	parameter int MAX_PATTERNS = pic_pkg::MAX_PATTERNS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [pic_pkg::CFGI_W-1:0]    cfg_index,
	input  logic [pic_pkg::CFGD_W-1:0]    cfg_data,
	input  logic [pic_pkg::CMD_W-1:0]     command,
	input  logic [pic_pkg::PIDX_W-1:0]    position_index,
	input  logic [pic_pkg::PAT_W-1:0]     pattern_number,
	input  pic_pkg::pic_cmd_t             cmd,
	output pic_pkg::pic_status_t          st,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pic_pkg::PAT_W-1:0]     value,
	output logic                          kept,
	output logic [pic_pkg::PCNT_W-1:0]    used_count
);
	import pic_pkg::*;

	localparam int PA_W = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
	localparam int MA_W = $clog2(MAX_PATTERNS);
	localparam logic [CNT_W-1:0] NPOS = CNT_W'(POSITIONS);
	localparam logic [CNT_W-1:0] NPAT = CNT_W'(MAX_PATTERNS);

	logic [SLEN_W-1:0] song_length_q;
	logic [PCNT_W-1:0] pattern_count_q;

	logic [PAT_W-1:0]  pos_mem [POSITIONS];
	logic [PAT_W-1:0]  rank_mem [MAX_PATTERNS];
	logic [POSITIONS-1:0]    pos_vld_q;
	logic [MAX_PATTERNS-1:0] used_q;

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  rank_cnt_q;
	logic [PCNT_W-1:0] used_total_q;
	logic              mark_q;

	logic [PAT_W-1:0]  rd_pos_q;
	logic              rd_vld_q;
	logic [PAT_W-1:0]  rd_rank_q;
	logic [CMD_W-1:0]  cmd_q;
	logic              pos_hit_q;
	logic              kept_q;

	logic              out_valid_q;
	logic [PAT_W-1:0]  value_q;
	logic              kept_out_q;
	logic [PCNT_W-1:0] used_count_q;

	logic [CNT_W-1:0]  len;
	logic [CNT_W-1:0]  pats;
	logic [CNT_W-1:0]  pidx;
	logic              pidx_ok;
	logic [PAT_W-1:0]  eff_pos;
	logic              eff_hit;
	logic              pos_we;
	logic [PA_W-1:0]   pos_wa;
	logic [PAT_W-1:0]  pos_wd;
	logic              pos_re;
	logic [PA_W-1:0]   pos_ra;
	logic              rank_we;
	logic              rank_re;
	logic [MA_W-1:0]   rank_ra;
	logic [PAT_W-1:0]  out_val;

	// Effective lengths, clipped to the table depths
	assign len  = ({1'b0, song_length_q} > NPOS) ? NPOS : {1'b0, song_length_q};
	assign pats = (pattern_count_q > NPAT) ? NPAT : pattern_count_q;

	assign pidx    = CNT_W'(position_index);
	assign pidx_ok = pidx < NPOS;

	// A slot never written reads as zero
	assign eff_pos = rd_vld_q ? rd_pos_q : '0;
	assign eff_hit = {1'b0, eff_pos} < pats;

	assign pos_we = (cmd.load && command == CMD_WRITE_POS && pidx_ok) || (cmd.rm_wr && eff_hit);
	assign pos_wa = cmd.load ? pidx[PA_W-1:0] : cnt_q[PA_W-1:0];
	assign pos_wd = cmd.load ? pattern_number : rd_rank_q;
	assign pos_re = cmd.load || cmd.mark_rd || cmd.rm_rd;
	assign pos_ra = cmd.load ? pidx[PA_W-1:0] : cnt_q[PA_W-1:0];

	assign rank_we = cmd.rank_step && used_q[cnt_q[MA_W-1:0]];
	assign rank_re = cmd.load || cmd.rm_rank;
	assign rank_ra = cmd.load ? pattern_number[MA_W-1:0] : eff_pos[MA_W-1:0];

	assign st.pos_done = cnt_q >= len;
	assign st.pat_done = cnt_q >= pats;
	assign st.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_wa] <= pos_wd;
		end
		if (pos_re) begin
			rd_pos_q <= pos_mem[pos_ra];
			rd_vld_q <= pos_vld_q[pos_ra];
		end
		if (rank_we) begin
			rank_mem[cnt_q[MA_W-1:0]] <= rank_cnt_q[PAT_W-1:0];
		end
		if (rank_re) begin
			rd_rank_q <= rank_mem[rank_ra];
		end
	end

	// Item fields kept for the result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= command;
			pos_hit_q <= pidx_ok && pos_vld_q[pidx[PA_W-1:0]];
			kept_q    <= ({1'b0, pattern_number} < NPAT) && used_q[pattern_number[MA_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			song_length_q   <= SLEN_W'(1);
			pattern_count_q <= PCNT_W'(1);
		end else if (cfg_write) begin
			if (cfg_index == CFG_SONG_LENGTH) begin
				song_length_q <= cfg_data[SLEN_W-1:0];
			end else begin
				pattern_count_q <= cfg_data[PCNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_vld_q <= '0;
		end else begin
			if (pos_we) begin
				pos_vld_q[pos_wa] <= 1'b1;
			end
			if (cmd.clr) begin
				// drop every slot beyond the song
				for (int p = 0; p < POSITIONS; p++) begin
					if (CNT_W'(p) >= len) begin
						pos_vld_q[p] <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			mark_q <= 1'b0;
		end else begin
			mark_q <= cmd.mark_rd;
			if (cmd.clr) begin
				used_q <= '0;
			end else if (mark_q && eff_hit) begin
				used_q[eff_pos[MA_W-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			rank_cnt_q   <= '0;
			used_total_q <= '0;
		end else begin
			if (cmd.clr || cmd.cnt_clr || cmd.rank_fin) begin
				cnt_q <= '0;
			end else if (cmd.mark_rd || cmd.rank_step || cmd.rm_wr) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.clr) begin
				rank_cnt_q <= '0;
			end else if (rank_we) begin
				rank_cnt_q <= rank_cnt_q + 1'b1;
			end
			if (cmd.rank_fin) begin
				used_total_q <= PCNT_W'(rank_cnt_q);
			end
		end
	end

	always_comb begin
		case (cmd_q)
			CMD_READ_POS: out_val = pos_hit_q ? rd_pos_q : '0;
			CMD_READ_MAP: out_val = kept_q ? rd_rank_q : '0;
			default:      out_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value_q      <= out_val;
			kept_out_q   <= (cmd_q == CMD_READ_MAP) && kept_q;
			used_count_q <= used_total_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign kept       = kept_out_q;
	assign used_count = used_count_q;

endmodule

// ----- rtl/pattern_index_compactor_unit.sv -----
// Pattern index compactor. Load song positions with write items, send one compute item,
// then query positions or the old-to-new pattern mapping; every item returns exactly
// one result carrying the used pattern count of the last compute. For a write, read or
// query item the accepting edge does the registered memory read, and the result then loads
// into the output register once that register is free; no new item is taken before that.
// A compute item runs one clear step, one pass over the positions of the clipped song
// length to mark used patterns and one pass over the clipped pattern count to assign
// ranks, then rewrites each position with a read, a rank lookup and a write, since the
// position table and the rank table each have one read and one write port; each pass
// ends with a closing step before the result loads. A full output register holds the
// next result back and the input waits behind it. Position and pattern flags clear at
// reset at once; no clearing pass is needed.
module pattern_index_compactor_unit #(
	parameter int POSITIONS    = pic_pkg::POSITIONS_DEF,
	parameter int MAX_PATTERNS = pic_pkg::MAX_PATTERNS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [pic_pkg::CFGI_W-1:0]    cfg_index,
	input  logic [pic_pkg::CFGD_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [pic_pkg::CMD_W-1:0]     command,
	input  logic [pic_pkg::PIDX_W-1:0]    position_index,
	input  logic [pic_pkg::PAT_W-1:0]     pattern_number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pic_pkg::PAT_W-1:0]     value,
	output logic                          kept,
	output logic [pic_pkg::PCNT_W-1:0]    used_count
);
	import pic_pkg::*;

	pic_cmd_t    cmd;
	pic_status_t st;

	pic_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.st       (st),
		.cmd      (cmd)
	);

	pic_dpath #(
		.POSITIONS    (POSITIONS),
		.MAX_PATTERNS (MAX_PATTERNS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.command        (command),
		.position_index (position_index),
		.pattern_number (pattern_number),
		.cmd            (cmd),
		.st             (st),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.value          (value),
		.kept           (kept),
		.used_count     (used_count)
	);

endmodule

// ----- tb/pattern_index_compactor_unit_tb.sv -----
`timescale 1ns / 1ps

module pattern_index_compactor_unit_tb;

	import pic_pkg::*;

	localparam int POSITIONS      = POSITIONS_DEF;
	localparam int MAX_PATTERNS   = MAX_PATTERNS_DEF;
	localparam int ITEM_TARGET    = 1800;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int STALL_LIMIT    = 8000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 20;

	typedef struct packed {
		logic [PAT_W-1:0]  value;
		logic              kept;
		logic [PCNT_W-1:0] used;
	} mapping_result_t;

	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFGI_W-1:0] cfg_index;
	logic [CFGD_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [CMD_W-1:0] command;
	logic [PIDX_W-1:0] position_index;
	logic [PAT_W-1:0] pattern_number;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PAT_W-1:0] value;
	logic kept;
	logic [PCNT_W-1:0] used_count;

	// Shadow of the block state
	logic [PAT_W-1:0]  position_model [POSITIONS];
	logic              used_model [MAX_PATTERNS];
	logic [PAT_W-1:0]  rank_model [MAX_PATTERNS];
	logic [PCNT_W-1:0] used_total_model;
	logic [SLEN_W-1:0] song_len_reg;
	logic [PCNT_W-1:0] pat_cnt_reg;

	mapping_result_t pending_results [$];
	int error_count = 0;
	int items_sent = 0;

	// Sender pacing
	bit sender_steady = 1'b1;
	int burst_left = 0;

	// Receiver pacing
	rx_mode_t rx_mode = RX_ALWAYS;
	int rx_period = 4;
	int rx_duty = 2;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int rx_tick = 0;

	pattern_index_compactor_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.position_index (position_index),
		.pattern_number (pattern_number),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.value          (value),
		.kept           (kept),
		.used_count     (used_count)
	);

	always #5 clk = ~clk;

	function automatic int song_len_eff();
		return (song_len_reg > POSITIONS) ? POSITIONS : int'(song_len_reg);
	endfunction

	function automatic int pat_cnt_eff();
		return (pat_cnt_reg > MAX_PATTERNS) ? MAX_PATTERNS : int'(pat_cnt_reg);
	endfunction

	function automatic void remap_patterns();
		int len;
		int pats;
		int count;
		logic [PAT_W-1:0] v;
		len = song_len_eff();
		pats = pat_cnt_eff();
		count = 0;
		for (int p = len; p < POSITIONS; p++)
			position_model[p] = '0;
		for (int k = 0; k < MAX_PATTERNS; k++) begin
			used_model[k] = 1'b0;
			rank_model[k] = '0;
		end
		for (int p = 0; p < len; p++) begin
			v = position_model[p];
			if (v < pats)
				used_model[v] = 1'b1;
		end
		for (int k = 0; k < pats; k++) begin
			if (used_model[k]) begin
				rank_model[k] = count[PAT_W-1:0];
				count++;
			end
		end
		used_total_model = count[PCNT_W-1:0];
		// rewrite in-song slots; values at or above the count stay as they are
		for (int p = 0; p < len; p++) begin
			v = position_model[p];
			if (v < pats)
				position_model[p] = rank_model[v];
		end
	endfunction

	function automatic mapping_result_t predict_result(logic [CMD_W-1:0] cmd,
			logic [PIDX_W-1:0] pidx, logic [PAT_W-1:0] pat);
		mapping_result_t r;
		r.value = '0;
		r.kept = 1'b0;
		case (cmd)
			CMD_WRITE_POS: begin
				if (pidx < POSITIONS)
					position_model[pidx] = pat;
			end
			CMD_COMPUTE: begin
				remap_patterns();
			end
			CMD_READ_POS: begin
				if (pidx < POSITIONS)
					r.value = position_model[pidx];
			end
			default: begin
				if (pat < MAX_PATTERNS && used_model[pat]) begin
					r.kept = 1'b1;
					r.value = rank_model[pat];
				end
			end
		endcase
		r.used = used_total_model;
		return r;
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PIDX_W-1:0] pidx,
			input logic [PAT_W-1:0] pat);
		int gap;
		if (!sender_steady && burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		position_index <= pidx;
		pattern_number <= pat;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(predict_result(cmd, pidx, pat));
		items_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// Drop valid and wait until every result is back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_register(input logic [CFGI_W-1:0] idx, input logic [CFGD_W-1:0] data);
		drain_results();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == CFG_SONG_LENGTH)
			song_len_reg = data[SLEN_W-1:0];
		else
			pat_cnt_reg = data;
	endtask

	function automatic logic [PIDX_W-1:0] pick_position();
		if (song_len_eff() > 0 && $urandom_range(0, 4) != 0)
			return PIDX_W'($urandom_range(0, song_len_eff() - 1));
		return PIDX_W'($urandom_range(0, POSITIONS - 1));
	endfunction

	function automatic logic [PAT_W-1:0] pick_pattern();
		if (pat_cnt_eff() > 0 && $urandom_range(0, 4) != 0)
			return PAT_W'($urandom_range(0, pat_cnt_eff() - 1));
		return PAT_W'($urandom_range(0, 255));
	endfunction

	task automatic test_reset_state();
		send_item(CMD_READ_POS, 7'd5, 8'd0);
		send_item(CMD_READ_MAP, 7'd0, 8'd0);
	endtask

	task automatic test_default_registers();
		send_item(CMD_WRITE_POS, 7'd0, 8'd0);
		send_item(CMD_WRITE_POS, 7'd1, 8'd7);
		send_item(CMD_COMPUTE, 7'd0, 8'd0);
		send_item(CMD_READ_MAP, 7'd0, 8'd0);
		send_item(CMD_READ_POS, 7'd1, 8'd0);
	endtask

	task automatic test_full_range();
		write_register(CFG_SONG_LENGTH, 9'd128);
		write_register(CFG_PATTERN_COUNT, 9'd256);
		send_item(CMD_WRITE_POS, 7'd127, 8'd255);
		send_item(CMD_WRITE_POS, 7'd0, 8'd255);
		send_item(CMD_WRITE_POS, 7'd64, 8'd3);
		send_item(CMD_COMPUTE, 7'd127, 8'd255);
		send_item(CMD_READ_POS, 7'd127, 8'd0);
		send_item(CMD_READ_MAP, 7'd0, 8'd255);
	endtask

	task automatic test_oversize_registers();
		write_register(CFG_SONG_LENGTH, 9'h1FF);
		write_register(CFG_PATTERN_COUNT, 9'h1FF);
		send_item(CMD_COMPUTE, 7'd0, 8'd0);
		write_register(CFG_PATTERN_COUNT, 9'd257);
		send_item(CMD_READ_MAP, 7'd0, 8'd2);
	endtask

	task automatic test_values_above_count();
		write_register(CFG_SONG_LENGTH, 9'd3);
		write_register(CFG_PATTERN_COUNT, 9'd4);
		send_item(CMD_WRITE_POS, 7'd0, 8'd200);
		send_item(CMD_WRITE_POS, 7'd1, 8'd2);
		send_item(CMD_WRITE_POS, 7'd2, 8'd9);
		send_item(CMD_COMPUTE, 7'd0, 8'd0);
		send_item(CMD_READ_POS, 7'd0, 8'd0);
		// mapping stays from the last compute even after the table changes
		send_item(CMD_WRITE_POS, 7'd1, 8'd3);
		send_item(CMD_READ_MAP, 7'd0, 8'd2);
	endtask

	task automatic test_zero_registers();
		write_register(CFG_SONG_LENGTH, 9'd0);
		send_item(CMD_COMPUTE, 7'd0, 8'd0);
		write_register(CFG_SONG_LENGTH, 9'd5);
		write_register(CFG_PATTERN_COUNT, 9'd0);
		send_item(CMD_WRITE_POS, 7'd4, 8'd0);
		send_item(CMD_COMPUTE, 7'd0, 8'd0);
		send_item(CMD_READ_POS, 7'd4, 8'd0);
	endtask

	task automatic test_output_backpressure();
		write_register(CFG_SONG_LENGTH, 9'd16);
		write_register(CFG_PATTERN_COUNT, 9'd32);
		sender_steady = 1'b1;
		rx_mode = RX_ALWAYS;
		hold_request = 1'b1;
		// keep offering while the receiver holds off, so the input stalls
		for (int i = 0; i < 12; i++)
			send_item(CMD_WRITE_POS, pick_position(), pick_pattern());
		send_item(CMD_COMPUTE, 7'd0, 8'd0);
		drain_results();
	endtask

	task automatic test_pause_until_drained();
		sender_steady = 1'b0;
		rx_mode = RX_RANDOM;
		for (int i = 0; i < 6; i++)
			send_item(CMD_READ_POS, pick_position(), 8'd0);
		drain_results();
		for (int i = 0; i < 6; i++)
			send_item(CMD_READ_MAP, 7'd0, pick_pattern());
	endtask

	task automatic test_random_songs();
		logic [CFGD_W-1:0] slen;
		logic [CFGD_W-1:0] pcnt;
		int n_writes;
		int n_reads;
		while (items_sent < ITEM_TARGET) begin
			slen = ($urandom_range(0, 7) == 0) ? CFGD_W'($urandom_range(0, 511))
				: CFGD_W'($urandom_range(1, 24));
			if ($urandom_range(0, 11) == 0)
				slen = 9'd128;
			pcnt = ($urandom_range(0, 7) == 0) ? CFGD_W'($urandom_range(0, 511))
				: CFGD_W'($urandom_range(1, 32));
			if ($urandom_range(0, 11) == 0)
				pcnt = 9'd256;
			write_register(CFG_SONG_LENGTH, slen);
			write_register(CFG_PATTERN_COUNT, pcnt);
			sender_steady = ($urandom_range(0, 3) == 0);
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_period = $urandom_range(2, 9);
			rx_duty = $urandom_range(1, rx_period - 1);

			n_writes = $urandom_range(1, 24);
			for (int i = 0; i < n_writes; i++) begin
				if ($urandom_range(0, 7) == 0)
					send_item(CMD_W'($urandom_range(0, 3)), PIDX_W'($urandom_range(0, 127)),
						PAT_W'($urandom_range(0, 255)));
				else
					send_item(CMD_WRITE_POS, pick_position(), pick_pattern());
			end
			send_item(CMD_COMPUTE, PIDX_W'($urandom_range(0, 127)),
				PAT_W'($urandom_range(0, 255)));
			for (int pass = 0; pass < 2; pass++) begin
				n_reads = $urandom_range(4, 20);
				for (int i = 0; i < n_reads; i++) begin
					if ($urandom_range(0, 1) == 0)
						send_item(CMD_READ_POS, pick_position(),
							PAT_W'($urandom_range(0, 255)));
					else
						send_item(CMD_READ_MAP, PIDX_W'($urandom_range(0, 127)),
							pick_pattern());
				end
				if (pass == 0) begin
					if ($urandom_range(0, 2) != 0)
						break;
					// compact an already compacted table again
					send_item(CMD_COMPUTE, PIDX_W'($urandom_range(0, 127)),
						PAT_W'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	// Receiver: stall pattern per phase, plus a long hold on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = RX_HOLD_CYCLES;
			hold_request = 1'b0;
		end
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: out_ready <= 1'b1;
				RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
				default:   out_ready <= ((rx_tick % rx_period) < rx_duty);
			endcase
		end
	end

	always @(posedge clk) begin
		mapping_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing pending, actual value %0d kept %0d used %0d",
					$time, value, kept, used_count);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (value !== exp_r.value) begin
					$display("%0t: value mismatch, expected %0d, actual %0d",
						$time, exp_r.value, value);
					error_count++;
				end
				if (kept !== exp_r.kept) begin
					$display("%0t: kept mismatch, expected %0d, actual %0d",
						$time, exp_r.kept, kept);
					error_count++;
				end
				if (used_count !== exp_r.used) begin
					$display("%0t: used_count mismatch, expected %0d, actual %0d",
						$time, exp_r.used, used_count);
					error_count++;
				end
			end
		end
	end

	// Watchdog: cycles with no item moving on either side
	always @(posedge clk) begin
		int stall_cycles;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("pattern_index_compactor_unit_tb: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_WRITE_POS;
		position_index = '0;
		pattern_number = '0;
		for (int p = 0; p < POSITIONS; p++)
			position_model[p] = '0;
		for (int k = 0; k < MAX_PATTERNS; k++) begin
			used_model[k] = 1'b0;
			rank_model[k] = '0;
		end
		used_total_model = '0;
		song_len_reg = 8'd1;
		pat_cnt_reg = 9'd1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_default_registers();
		test_full_range();
		test_oversize_registers();
		test_values_above_count();
		test_zero_registers();
		test_output_backpressure();
		test_pause_until_drained();
		test_random_songs();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("pattern_index_compactor_unit_tb: done, clean");
		else
			$display("pattern_index_compactor_unit_tb: done, errors");
		$finish;
	end

endmodule
